FILE: rtl/dc_pkg.sv
// Shared types and constants for the density clustering block.
// No dependencies; every other file but dc_ram imports this package.
package dc_pkg;

    // Coordinate width of the command word
    localparam int COORD_BITS = 16;

    // Command codes
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_e;

    // Configuration register indexes
    localparam logic [1:0] CFG_EPS  = 2'd0;
    localparam logic [1:0] CFG_MINN = 2'd1;
    localparam logic [1:0] CFG_DIMS = 2'd2;

    // Label value for noise and unknown points
    localparam logic signed [10:0] LABEL_NONE = -11'sd1;

    // Command word
    typedef struct packed {
        logic [1:0]                   command;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
        logic [9:0]                   point_index;
    } item_t;

    // Response word
    typedef struct packed {
        logic signed [10:0] cluster_label;
        logic [10:0]        cluster_count;
        logic [10:0]        stored_points;
        logic               overflow;
    } result_t;

    // Status of the distance pipeline
    typedef struct packed {
        logic valid;
        logic near;
        logic active;
    } pipe_ctl_t;

endpackage

FILE: rtl/dc_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing.
module dc_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);
    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    // Write, and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/dc_dist_pipe.sv
// Three-stage squared distance pipeline: abs differences, squares, sum and compare.
// Depends on dc_pkg.
module dc_dist_pipe #(
    parameter int AW = 10,
    parameter int SW = 14
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [AW-1:0]                      in_idx,
    input  logic [SW-1:0]                      in_stat,
    input  logic [3*dc_pkg::COORD_BITS-1:0]    in_coord,
    input  logic [3*dc_pkg::COORD_BITS-1:0]    p_coord,
    input  logic                               dims3,
    input  logic [31:0]                        eps2,
    output dc_pkg::pipe_ctl_t                  ctl,
    output logic [AW-1:0]                      out_idx,
    output logic [SW-1:0]                      out_stat
);
    import dc_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int SUM_W = 2 * CB + 2;

    logic          vb_reg, vc_reg, vd_reg;
    logic [AW-1:0] ib_reg, ic_reg, id_reg;
    logic [SW-1:0] sb_reg, sc_reg, sd_reg;
    logic [CB-1:0] ad_reg [3];
    logic [2*CB-1:0] sq_reg [3];
    logic          near_reg;
    logic [CB-1:0] ad_next [3];
    logic [SUM_W-1:0] sum;

    // Absolute difference per axis; z drops out in 2D
    always_comb
    begin
        logic signed [CB:0] d;
        for (int k = 0; k < 3; k++)
        begin
            d = $signed({in_coord[(3-k)*CB-1], in_coord[(3-k)*CB-1 -: CB]})
                - $signed({p_coord[(3-k)*CB-1], p_coord[(3-k)*CB-1 -: CB]});
            ad_next[k] = d[CB] ? CB'(-d) : d[CB-1:0];
        end
        if (!dims3)
        begin
            ad_next[2] = '0;
        end
    end

    assign sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            vb_reg <= in_valid;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        ib_reg   <= in_idx;
        sb_reg   <= in_stat;
        ad_reg   <= ad_next;
        ic_reg   <= ib_reg;
        sc_reg   <= sb_reg;
        for (int k = 0; k < 3; k++)
        begin
            sq_reg[k] <= ad_reg[k] * ad_reg[k];
        end
        id_reg   <= ic_reg;
        sd_reg   <= sc_reg;
        near_reg <= sum < SUM_W'(eps2);
    end

    assign ctl.valid  = vd_reg;
    assign ctl.near   = near_reg;
    assign ctl.active = vb_reg | vc_reg | vd_reg;
    assign out_idx    = id_reg;
    assign out_stat   = sd_reg;
endmodule

FILE: rtl/density_clustering.sv
// Density clustering top level: command decode, run sequencer and memories.
// Depends on dc_pkg, dc_ram and dc_dist_pipe.
//
//  channel   | signals                               | word
//  ----------+---------------------------------------+------------------
//  command   | start, busy, item                     | dc_pkg::item_t
//  response  | rsp_valid, rsp                        | dc_pkg::result_t
//  config    | cfg_valid, cfg_ready, cfg_index/data  | 2-bit index, 16-bit data
//
// Load and clear answer in the next cycle with busy staying low; a read
// answers through the S_READ state, after one status RAM read.
// A run makes one or two distance scans over all N points per point,
// paced by the single read port of the coordinate RAM, plus the outer
// loop and stack pop states per point.
// Each run opens with a sweep over the status RAM that marks every point as noise.
// Reset clears control state only; responses cannot be stalled.
module density_clustering #(
    parameter int MAX_POINTS = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  dc_pkg::item_t   item,
    output logic            rsp_valid,
    output dc_pkg::result_t rsp,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data
);
    import dc_pkg::*;

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SW    = CNT_W + 3;
    localparam int CW    = 3 * COORD_BITS;
    localparam logic [SW-1:0] STAT_NOISE = '0;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_CLEAR, S_OUTER, S_OUTER_CHK, S_COUNT, S_DECIDE,
        S_PUSH, S_POP, S_POP_WAIT, S_POP_CHK, S_FINISH
    } state_t;

    state_t           state_reg;
    logic [15:0]      eps_reg;
    logic [10:0]      minn_reg;
    logic [1:0]       dims_reg;
    logic [31:0]      eps2_reg;
    logic [CNT_W-1:0] total_reg, cluster_reg, depth_reg, cnt_reg, i_reg, j_reg;
    logic [AW-1:0]    p_reg, issue_idx_reg;
    logic [CW-1:0]    pcoord_reg;
    logic             p_q_reg, seed_reg, issue_reg, rd_ok_reg, rsp_valid_reg;
    result_t          rsp_reg;

    logic             accept, full, core, issue, push;
    logic             coord_we, stat_we, stk_we;
    logic [AW-1:0]    coord_waddr, stat_waddr, stk_waddr;
    logic [AW-1:0]    coord_raddr, stat_raddr, stk_raddr;
    logic [CW-1:0]    coord_wdata, coord_rdata;
    logic [SW-1:0]    stat_wdata, stat_rdata, pipe_stat;
    logic [AW-1:0]    stk_wdata, stk_rdata, pipe_idx;
    pipe_ctl_t        pipe_ctl;
    logic [10:0]      total_out;

    assign accept    = start && !busy;
    assign full      = total_reg == CNT_W'(MAX_POINTS);
    assign core      = {{CNT_W{1'b0}}, minn_reg} <= {11'b0, cnt_reg};
    assign push      = pipe_ctl.valid && pipe_ctl.near && !pipe_stat[SW-1]
                       && !pipe_stat[SW-2] && depth_reg != CNT_W'(MAX_POINTS);
    assign busy      = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign total_out = 11'(total_reg);

    // Memory port steering
    always_comb
    begin
        coord_we    = 1'b0;
        coord_waddr = total_reg[AW-1:0];
        coord_wdata = {item.coord_x, item.coord_y, item.coord_z};
        stat_we     = 1'b0;
        stat_waddr  = total_reg[AW-1:0];
        stat_wdata  = STAT_NOISE;
        stk_we      = 1'b0;
        stk_waddr   = depth_reg[AW-1:0];
        stk_wdata   = pipe_idx;
        coord_raddr = j_reg[AW-1:0];
        stat_raddr  = j_reg[AW-1:0];
        stk_raddr   = AW'(depth_reg - CNT_W'(1));
        issue       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && item.command == CMD_LOAD && !full)
                begin
                    coord_we = 1'b1;
                    stat_we  = 1'b1;
                end
                stat_raddr = AW'({{AW{1'b0}}, item.point_index});
            end
            S_CLEAR:
            begin
                stat_we    = j_reg != total_reg;
                stat_waddr = j_reg[AW-1:0];
            end
            S_OUTER:
            begin
                coord_raddr = i_reg[AW-1:0];
                stat_raddr  = i_reg[AW-1:0];
            end
            S_COUNT:
            begin
                issue = j_reg != total_reg;
            end
            S_PUSH:
            begin
                issue      = j_reg != total_reg;
                stat_we    = push;
                stat_waddr = pipe_idx;
                stat_wdata = {1'b0, 1'b1, pipe_stat[SW-3:0]};
                stk_we     = push;
            end
            S_DECIDE:
            begin
                stat_we    = seed_reg && core;
                stat_waddr = p_reg;
                stat_wdata = {1'b1, p_q_reg, 1'b1, cluster_reg};
            end
            S_POP_WAIT:
            begin
                coord_raddr = stk_rdata;
                stat_raddr  = stk_rdata;
            end
            S_POP_CHK:
            begin
                stat_we    = !stat_rdata[SW-1];
                stat_waddr = p_reg;
                stat_wdata = {1'b1, stat_rdata[SW-2], 1'b1, cluster_reg};
            end
            default:
            begin
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg  <= '0;
            minn_reg <= 11'd4;
            dims_reg <= 2'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_EPS:
                begin
                    eps_reg <= cfg_data;
                end
                CFG_MINN:
                begin
                    minn_reg <= cfg_data[10:0];
                end
                CFG_DIMS:
                begin
                    dims_reg <= cfg_data[1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Command decode and run sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            cluster_reg   <= '0;
            depth_reg     <= '0;
            cnt_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            issue_reg     <= 1'b0;
            issue_idx_reg <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            seed_reg      <= 1'b0;
            eps2_reg      <= '0;
            rd_ok_reg     <= 1'b0;
            p_reg         <= '0;
            pcoord_reg    <= '0;
            p_q_reg       <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= 1'b0;
            issue_reg     <= issue;
            issue_idx_reg <= j_reg[AW-1:0];
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (item.command)
                            CMD_LOAD:
                            begin
                                rsp_reg.cluster_label <= LABEL_NONE;
                                rsp_reg.cluster_count <= 11'(cluster_reg);
                                rsp_reg.overflow      <= full;
                                rsp_reg.stored_points <= full ? total_out
                                                              : total_out + 11'd1;
                                rsp_valid_reg         <= 1'b1;
                                if (!full)
                                begin
                                    total_reg <= total_reg + CNT_W'(1);
                                end
                            end
                            CMD_RUN:
                            begin
                                eps2_reg    <= eps_reg * eps_reg;
                                cluster_reg <= '0;
                                depth_reg   <= '0;
                                j_reg       <= '0;
                                state_reg   <= S_CLEAR;
                            end
                            CMD_READ:
                            begin
                                rd_ok_reg <= {{CNT_W{1'b0}}, item.point_index}
                                             < {10'b0, total_reg};
                                state_reg <= S_READ;
                            end
                            CMD_CLEAR:
                            begin
                                total_reg     <= '0;
                                cluster_reg   <= '0;
                                rsp_reg       <= '{LABEL_NONE, 11'd0, 11'd0, 1'b0};
                                rsp_valid_reg <= 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    rsp_reg.cluster_label <= (rd_ok_reg && stat_rdata[SW-3])
                                             ? 11'(stat_rdata[CNT_W-1:0]) : LABEL_NONE;
                    rsp_reg.cluster_count <= 11'(cluster_reg);
                    rsp_reg.stored_points <= total_out;
                    rsp_reg.overflow      <= 1'b0;
                    rsp_valid_reg         <= 1'b1;
                    state_reg             <= S_IDLE;
                end
                S_CLEAR:
                begin
                    if (j_reg != total_reg)
                    begin
                        j_reg <= j_reg + CNT_W'(1);
                    end
                    else
                    begin
                        i_reg     <= '0;
                        state_reg <= S_OUTER;
                    end
                end
                S_OUTER:
                begin
                    state_reg <= (i_reg == total_reg) ? S_FINISH : S_OUTER_CHK;
                end
                S_OUTER_CHK:
                begin
                    if (stat_rdata[SW-1])
                    begin
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= S_OUTER;
                    end
                    else
                    begin
                        p_reg      <= i_reg[AW-1:0];
                        pcoord_reg <= coord_rdata;
                        p_q_reg    <= stat_rdata[SW-2];
                        seed_reg   <= 1'b1;
                        j_reg      <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= S_COUNT;
                    end
                end
                S_COUNT:
                begin
                    if (j_reg != total_reg)
                    begin
                        j_reg <= j_reg + CNT_W'(1);
                    end
                    if (pipe_ctl.valid && pipe_ctl.near)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    if (j_reg == total_reg && !issue_reg && !pipe_ctl.active)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    j_reg <= '0;
                    priority if (core)
                    begin
                        state_reg <= S_PUSH;
                    end
                    else if (seed_reg)
                    begin
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= S_OUTER;
                    end
                    else
                    begin
                        state_reg <= S_POP;
                    end
                end
                S_PUSH:
                begin
                    if (j_reg != total_reg)
                    begin
                        j_reg <= j_reg + CNT_W'(1);
                    end
                    if (push)
                    begin
                        depth_reg <= depth_reg + CNT_W'(1);
                    end
                    if (j_reg == total_reg && !issue_reg && !pipe_ctl.active)
                    begin
                        state_reg <= S_POP;
                    end
                end
                S_POP:
                begin
                    if (depth_reg == '0)
                    begin
                        cluster_reg <= cluster_reg + CNT_W'(1);
                        i_reg       <= i_reg + CNT_W'(1);
                        state_reg   <= S_OUTER;
                    end
                    else
                    begin
                        depth_reg <= depth_reg - CNT_W'(1);
                        state_reg <= S_POP_WAIT;
                    end
                end
                S_POP_WAIT:
                begin
                    p_reg     <= stk_rdata;
                    state_reg <= S_POP_CHK;
                end
                S_POP_CHK:
                begin
                    if (stat_rdata[SW-1])
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        pcoord_reg <= coord_rdata;
                        seed_reg   <= 1'b0;
                        j_reg      <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= S_COUNT;
                    end
                end
                S_FINISH:
                begin
                    rsp_reg.cluster_label <= LABEL_NONE;
                    rsp_reg.cluster_count <= 11'(cluster_reg);
                    rsp_reg.stored_points <= total_out;
                    rsp_reg.overflow      <= 1'b0;
                    rsp_valid_reg         <= 1'b1;
                    state_reg             <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Point coordinates
    dc_ram #(.W(CW), .DEPTH(MAX_POINTS)) u_coord (
        .clk(clk), .we(coord_we), .waddr(coord_waddr), .wdata(coord_wdata),
        .raddr(coord_raddr), .rdata(coord_rdata)
    );

    // Visited, queued and label per point
    dc_ram #(.W(SW), .DEPTH(MAX_POINTS)) u_status (
        .clk(clk), .we(stat_we), .waddr(stat_waddr), .wdata(stat_wdata),
        .raddr(stat_raddr), .rdata(stat_rdata)
    );

    // Frontier stack
    dc_ram #(.W(AW), .DEPTH(MAX_POINTS)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    // Neighbour test against the current point
    dc_dist_pipe #(.AW(AW), .SW(SW)) u_pipe (
        .clk(clk), .rst_n(rst_n), .in_valid(issue_reg), .in_idx(issue_idx_reg),
        .in_stat(stat_rdata), .in_coord(coord_rdata), .p_coord(pcoord_reg),
        .dims3(dims_reg == 2'd3), .eps2(eps2_reg), .ctl(pipe_ctl),
        .out_idx(pipe_idx), .out_stat(pipe_stat)
    );
endmodule

FILE: rtl/dc_checker.sv
// Port-level checks for the density clustering block, bound to the top level.
// Depends on dc_pkg.
module dc_checker #(
    parameter int MAX_POINTS = 1024
) (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input dc_pkg::item_t   item,
    input logic            rsp_valid,
    input dc_pkg::result_t rsp
);
    import dc_pkg::*;

    // A load answers in the next cycle with no label
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.command == CMD_LOAD
        |=> rsp_valid && rsp.cluster_label == LABEL_NONE)
        else $error("load word not answered");

    // A read holds busy and then answers
    a_read: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.command == CMD_READ |=> busy ##1 rsp_valid)
        else $error("read word not answered");

    // A clear empties the store
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.command == CMD_CLEAR
        |=> rsp_valid && rsp.stored_points == 11'd0 && rsp.cluster_count == 11'd0)
        else $error("clear word wrong");

    // Overflow only when the store is full
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.overflow |-> rsp.stored_points == 11'(MAX_POINTS))
        else $error("overflow with room left");
endmodule

bind density_clustering dc_checker #(.MAX_POINTS(MAX_POINTS)) u_dc_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
    .rsp_valid(rsp_valid), .rsp(rsp)
);

FILE: tb/sv/tb_density_clustering.sv
// Testbench for density_clustering: directed and random command words checked
// against a behavioural clustering predictor held in a small scoreboard class.
// Depends on dc_pkg and the density_clustering RTL.
`timescale 1ns / 1ps

module tb_density_clustering;
    import dc_pkg::*;

    localparam int NPTS      = 1024;
    localparam int LIMIT_CYC = 4000000;

    // Scoreboard: own copy of the point store, labels and registers
    class cluster_board;
        int unsigned eps_r;
        int unsigned min_n;
        int unsigned dims;
        logic signed [15:0] px [NPTS];
        logic signed [15:0] py [NPTS];
        logic signed [15:0] pz [NPTS];
        int lbl [NPTS];
        int unsigned n_pts;
        int unsigned n_clu;
        result_t pending [$];
        int errors;

        function new();
            eps_r = 0; min_n = 4; dims = 2; n_pts = 0; n_clu = 0; errors = 0;
            for (int i = 0; i < NPTS; i++) lbl[i] = -1;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == CFG_EPS) eps_r = val;
            else if (idx == CFG_MINN) min_n = val[10:0];
            else if (idx == CFG_DIMS) dims = val[1:0];
        endfunction

        function bit near(int a, int b);
            longint unsigned d, dd;
            longint da;
            da = px[a] - px[b]; d = da * da;
            da = py[a] - py[b]; d += da * da;
            if (dims == 3)
            begin
                da = pz[a] - pz[b]; d += da * da;
            end
            dd = longint'(eps_r) * eps_r;
            return d < dd;
        endfunction

        function bit core(int p);
            int unsigned c;
            c = 0;
            for (int j = 0; j < n_pts; j++) if (near(p, j)) c++;
            return c >= min_n;
        endfunction

        function void run_labels();
            bit seen [NPTS];
            bit queued [NPTS];
            int stk [$];
            int p;
            for (int i = 0; i < NPTS; i++)
            begin
                lbl[i] = -1; seen[i] = 0; queued[i] = 0;
            end
            n_clu = 0;
            for (int i = 0; i < n_pts; i++)
            begin
                if (seen[i] || !core(i)) continue;
                seen[i] = 1; lbl[i] = n_clu;
                for (int j = 0; j < n_pts; j++)
                    if (!seen[j] && !queued[j] && near(i, j))
                    begin
                        queued[j] = 1; stk.insert(stk.size(), j);
                    end
                while (stk.size() > 0)
                begin
                    p = stk[stk.size() - 1];
                    stk.delete(stk.size() - 1);
                    if (seen[p]) continue;
                    seen[p] = 1; lbl[p] = n_clu;
                    if (core(p))
                        for (int j = 0; j < n_pts; j++)
                            if (!seen[j] && !queued[j] && near(p, j))
                            begin
                                queued[j] = 1; stk.insert(stk.size(), j);
                            end
                end
                n_clu++;
            end
        endfunction

        // Note an accepted command word and queue its response
        function void note_item(item_t it);
            result_t r;
            r = '0;
            r.cluster_label = LABEL_NONE;
            unique case (cmd_e'(it.command))
                CMD_LOAD:
                    if (n_pts < NPTS)
                    begin
                        px[n_pts] = it.coord_x; py[n_pts] = it.coord_y;
                        pz[n_pts] = it.coord_z; lbl[n_pts] = -1; n_pts++;
                    end
                    else r.overflow = 1'b1;
                CMD_RUN: run_labels();
                CMD_READ:
                    if (it.point_index < n_pts)
                        r.cluster_label = 11'(lbl[it.point_index]);
                CMD_CLEAR:
                begin
                    n_pts = 0; n_clu = 0;
                end
            endcase
            r.cluster_count = 11'(n_clu);
            r.stored_points = 11'(n_pts);
            pending.insert(pending.size(), r);
        endfunction

        // One line per mismatch, counted
        task report(string msg);
            $display("MISMATCH %s", msg);
            errors++;
        endtask

        task check_word(result_t got);
            result_t w;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected response %p", got));
                return;
            end
            w = pending.pop_front();
            if (got.cluster_label !== w.cluster_label)
                report($sformatf("cluster_label: got %p want %p", got, w));
            if (got.cluster_count !== w.cluster_count)
                report($sformatf("cluster_count: got %p want %p", got, w));
            if (got.stored_points !== w.stored_points)
                report($sformatf("stored_points: got %p want %p", got, w));
            if (got.overflow !== w.overflow)
                report($sformatf("overflow: got %p want %p", got, w));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    item_t item = '0;
    logic rsp_valid;
    result_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    cluster_board board = new();
    int unsigned idle_pct = 12;
    longint cycles = 0;

    density_clustering u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .rsp_valid(rsp_valid), .rsp(rsp), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Response checking and timeout
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && rsp_valid) board.check_word(rsp);
        if (cycles > LIMIT_CYC)
        begin
            $display("density_clustering test failed");
            $finish;
        end
    end

    // Send one command word, with random idle gaps ahead of it; start stays
    // high on return so the next word can follow without a gap
    task automatic send_word(item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_item(it);
        @(negedge clk);
    endtask

    // Drop start and wait for every outstanding response
    task automatic wait_drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        wait_drain();
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic item_t mk(cmd_e c, int x, int y, int z, int idx);
        item_t it;
        it.command = c; it.coord_x = 16'(x); it.coord_y = 16'(y);
        it.coord_z = 16'(z);
        it.point_index = 10'(idx);
        return it;
    endfunction

    // Random load around a few centres, so clusters really form
    function automatic item_t rand_load(int spread);
        int cx, cy;
        cx = $urandom_range(3) * 200 - 300;
        cy = $urandom_range(3) * 200 - 300;
        if ($urandom_range(9) == 0)
            return mk(CMD_LOAD, $urandom, $urandom, $urandom, 0);
        return mk(CMD_LOAD, cx + $urandom_range(2 * spread) - spread,
                  cy + $urandom_range(2 * spread) - spread,
                  $urandom_range(2 * spread) - spread, 0);
    endfunction

    task automatic random_phase(int n);
        int np;
        repeat (n)
        begin
            np = $urandom_range(20, 4);
            repeat (np) send_word(rand_load(40));
            send_word(mk(CMD_RUN, 0, 0, 0, 0));
            repeat ($urandom_range(6, 2))
                send_word(mk(CMD_READ, 0, 0, 0, $urandom_range(np + 1)));
            if ($urandom_range(3) == 0) send_word(mk(CMD_READ, 0, 0, 0, $urandom));
            send_word(mk(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom));
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset defaults, empty run, extremes, load after run, clear
        send_word(mk(CMD_RUN, 0, 0, 0, 0));
        send_word(mk(CMD_READ, 0, 0, 0, 0));
        write_reg(CFG_EPS, 16'd2);
        write_reg(CFG_MINN, 16'd2);
        write_reg(CFG_DIMS, 16'd3);
        send_word(mk(CMD_LOAD, -32768, -32768, -32768, 1023));
        send_word(mk(CMD_LOAD, 32767, 32767, 32767, 0));
        send_word(mk(CMD_LOAD, 32767, 32766, 32767, 0));
        send_word(mk(CMD_LOAD, 0, 0, 0, 0));
        send_word(mk(CMD_LOAD, 0, 0, 1, 0));
        send_word(mk(CMD_RUN, 0, 0, 0, 0));
        send_word(mk(CMD_LOAD, 1, 0, 0, 0));
        for (int i = 0; i < 7; i++) send_word(mk(CMD_READ, 0, 0, 0, i));
        send_word(mk(CMD_READ, 0, 0, 0, 1023));
        write_reg(CFG_DIMS, 16'd0);
        write_reg(CFG_EPS, 16'hFFFF);
        write_reg(CFG_MINN, 16'd0);
        send_word(mk(CMD_RUN, 0, 0, 0, 0));
        send_word(mk(CMD_READ, 0, 0, 0, 0));
        send_word(mk(CMD_CLEAR, 0, 0, 0, 0));
        send_word(mk(CMD_READ, 0, 0, 0, 0));

        // Random phases across settings and idling patterns
        write_reg(CFG_EPS, 16'd30);
        write_reg(CFG_MINN, 16'd3);
        write_reg(CFG_DIMS, 16'd2);
        random_phase(2);
        wait_drain();
        idle_pct = 71;
        write_reg(CFG_DIMS, 16'd3);
        write_reg(CFG_EPS, 16'd60);
        write_reg(CFG_MINN, 16'd1);
        random_phase(1);
        idle_pct = 0;
        write_reg(CFG_DIMS, 16'd1);
        write_reg(CFG_EPS, 16'd45);
        write_reg(CFG_MINN, 16'd5);
        random_phase(1);

        wait_drain();
        repeat (50) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("density_clustering test passed");
        else
            $display("density_clustering test failed");
        $finish;
    end
endmodule

FILE: density_clustering.f
rtl/dc_pkg.sv
rtl/dc_ram.sv
rtl/dc_dist_pipe.sv
rtl/density_clustering.sv
rtl/dc_checker.sv
tb/sv/tb_density_clustering.sv
